FILE: src/djob_pkg.sv
// shared types, constants and the jet colormap function for the depth overlay blender
package djob_pkg;

  localparam int RawW   = 16;
  localparam int ScaleW = 24;
  localparam int MmW    = 16;
  localparam int AlphaW = 9;
  localparam int ChanW  = 8;
  localparam int DistW  = RawW + ScaleW;
  localparam int SpanW  = MmW + 16;
  localparam int QuoW   = 8;
  localparam int RemW   = MmW + QuoW;
  localparam int CfgW   = 24;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_SCALE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 3'd4;

  localparam logic [ScaleW-1:0] SCALE_RST  = 24'd65536;
  localparam logic [MmW-1:0]    MIN_RST    = 16'd300;
  localparam logic [MmW-1:0]    MAX_RST    = 16'd5000;
  localparam logic [AlphaW-1:0] ALPHA_RST  = 9'd128;
  localparam logic [AlphaW-1:0] ALPHA_ONE  = 9'd256;

  // colors and decision flags that ride along with each pixel
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             hit;
    logic             zspan;
  } side_t;

  // restoring divider working set
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [MmW-1:0]  den;
    logic [QuoW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // five-segment jet map, borders at 31, 95, 159 and 223
  function automatic rgb_t jet_map(logic [QuoW-1:0] v);
    logic [10:0] v4;
    logic [10:0] r;
    logic [10:0] g;
    logic [10:0] b;
    rgb_t        res;
    v4 = {1'b0, v, 2'b00};
    if (v <= 8'd31) begin
      r = 11'd0;       g = 11'd0;       b = 11'd127 + v4;
    end else if (v <= 8'd95) begin
      r = 11'd0;       g = v4 - 11'd128; b = 11'd255;
    end else if (v <= 8'd159) begin
      r = v4 - 11'd383; g = 11'd255;     b = 11'd637 - v4;
    end else if (v <= 8'd223) begin
      r = 11'd255;     g = 11'd892 - v4; b = 11'd0;
    end else begin
      r = 11'd1147 - v4; g = 11'd0;      b = 11'd0;
    end
    res.red   = r[ChanW-1:0];
    res.green = g[ChanW-1:0];
    res.blue  = b[ChanW-1:0];
    return res;
  endfunction

endpackage

FILE: src/djob_front.sv
// front stages: depth scaling, range test and divider operand setup
module djob_front (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  logic [djob_pkg::RawW-1:0]  raw_depth,
  input  logic [djob_pkg::ChanW-1:0] color_red,
  input  logic [djob_pkg::ChanW-1:0] color_green,
  input  logic [djob_pkg::ChanW-1:0] color_blue,
  input  logic [djob_pkg::ScaleW-1:0] scale,
  input  logic [djob_pkg::MmW-1:0]   min_mm,
  input  logic [djob_pkg::MmW-1:0]   max_mm,
  input  logic                       overlay_enable,
  output djob_pkg::div_t             div_o,
  output djob_pkg::side_t            side_o
);
  import djob_pkg::*;

  logic [DistW-1:0] dist_r;
  side_t            side1_r;
  logic [SpanW-1:0] x2_r;
  side_t            side2_r;
  side_t            side2_nxt;
  div_t             div3_r;
  side_t            side3_r;

  logic [SpanW-1:0] lo;
  logic [SpanW-1:0] hi;
  logic             in_range;
  logic [DistW-1:0] n255;

  assign lo = {min_mm, 16'b0};
  assign hi = {max_mm, 16'b0};
  assign in_range = (dist_r >= {{(DistW-SpanW){1'b0}}, lo}) &&
                    (dist_r <= {{(DistW-SpanW){1'b0}}, hi});
  // 255*x as (x<<8)-x, then drop the 16 fraction bits of the span
  assign n255 = {x2_r, 8'b0} - {8'b0, x2_r};

  always_comb begin
    side2_nxt       = side1_r;
    side2_nxt.hit   = side1_r.hit && in_range;
    side2_nxt.zspan = (max_mm == min_mm);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dist_r        <= {{ScaleW{1'b0}}, raw_depth} * {{RawW{1'b0}}, scale};
      side1_r.red   <= color_red;
      side1_r.green <= color_green;
      side1_r.blue  <= color_blue;
      side1_r.hit   <= overlay_enable && (raw_depth != '0);
      side1_r.zspan <= 1'b0;
    end
    if (en[1]) begin
      x2_r    <= dist_r[SpanW-1:0] - lo;
      side2_r <= side2_nxt;
    end
    if (en[2]) begin
      div3_r.rem <= n255[DistW-1:16];
      div3_r.den <= max_mm - min_mm;
      div3_r.quo <= '0;
      side3_r    <= side2_r;
    end
  end

  assign div_o  = div3_r;
  assign side_o = side3_r;

endmodule

FILE: src/djob_div.sv
// divider stage: two restoring quotient bits per stage
module djob_div #(
  parameter int HiBit = djob_pkg::QuoW - 1
) (
  input  logic            clk,
  input  logic            en,
  input  djob_pkg::div_t  div_i,
  input  djob_pkg::side_t side_i,
  output djob_pkg::div_t  div_o,
  output djob_pkg::side_t side_o
);
  import djob_pkg::*;

  div_t  div_nxt;
  div_t  div_r;
  side_t side_r;

  always_comb begin
    logic [RemW-1:0] trial;
    div_nxt = div_i;
    for (int j = 0; j < 2; j++) begin
      trial = {{(RemW-MmW){1'b0}}, div_nxt.den} << (HiBit - j);
      if (div_nxt.rem >= trial) begin
        div_nxt.rem            = div_nxt.rem - trial;
        div_nxt.quo[HiBit - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_nxt;
      side_r <= side_i;
    end
  end

  assign div_o  = div_r;
  assign side_o = side_r;

endmodule

FILE: src/djob_blend.sv
// back stages: jet lookup and alpha blend into the output register
module djob_blend (
  input  logic                        clk,
  input  logic [1:0]                  en,
  input  djob_pkg::div_t              div_i,
  input  djob_pkg::side_t             side_i,
  input  logic [djob_pkg::AlphaW-1:0] alpha,
  output logic [djob_pkg::ChanW-1:0]  out_red,
  output logic [djob_pkg::ChanW-1:0]  out_green,
  output logic [djob_pkg::ChanW-1:0]  out_blue,
  output logic                        out_overlaid
);
  import djob_pkg::*;

  rgb_t             jet_r;
  side_t            side_r;
  logic [ChanW-1:0] red_r;
  logic [ChanW-1:0] green_r;
  logic [ChanW-1:0] blue_r;
  logic             overlaid_r;

  logic [QuoW-1:0]   v;
  logic [AlphaW-1:0] a;
  logic [AlphaW-1:0] na;
  logic [16:0]       mix_red;
  logic [16:0]       mix_green;
  logic [16:0]       mix_blue;

  // empty range maps to the first color of the map
  assign v  = side_i.zspan ? '0 : div_i.quo;
  assign a  = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign na = ALPHA_ONE - a;

  assign mix_red   = {8'b0, na} * {9'b0, side_r.red}   + {8'b0, a} * {9'b0, jet_r.red}   + 17'd128;
  assign mix_green = {8'b0, na} * {9'b0, side_r.green} + {8'b0, a} * {9'b0, jet_r.green} + 17'd128;
  assign mix_blue  = {8'b0, na} * {9'b0, side_r.blue}  + {8'b0, a} * {9'b0, jet_r.blue}  + 17'd128;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      jet_r  <= jet_map(v);
      side_r <= side_i;
    end
    if (en[1]) begin
      red_r      <= side_r.hit ? mix_red[15:8]   : side_r.red;
      green_r    <= side_r.hit ? mix_green[15:8] : side_r.green;
      blue_r     <= side_r.hit ? mix_blue[15:8]  : side_r.blue;
      overlaid_r <= side_r.hit;
    end
  end

  assign out_red      = red_r;
  assign out_green    = green_r;
  assign out_blue     = blue_r;
  assign out_overlaid = overlaid_r;

endmodule

FILE: src/depth_jet_overlay_blend.sv
// top level: depth to jet colormap overlay on a color pixel stream
//
// Usage: one aligned pair of raw depth and RGB color enters per transfer on
// the in_ valid/ready channel; the fused pixel leaves on the out_ channel,
// with out_overlaid high when the colormap was blended in and low when the
// color passed through (overlay off, no depth, or distance outside the range).
// Throughput is one pixel per clock while out_ready is high. Stages: scale
// multiply, range test, operand setup, four divider stages of two quotient
// bits each, jet lookup, blend/output register. Every stage holds its own
// valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles are squeezed out and in_ready stays high while any stage is free.
// When the receiver stalls, the output holds and the pipeline fills; in_ready
// drops only once all nine stages are full. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no pixel is in
// flight, which the block does not enforce; indices above 4 are ignored.
// Synchronous reset empties the pipeline and loads the register defaults.
module depth_jet_overlay_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [djob_pkg::RawW-1:0]     in_raw_depth,
  input  logic [djob_pkg::ChanW-1:0]    in_color_red,
  input  logic [djob_pkg::ChanW-1:0]    in_color_green,
  input  logic [djob_pkg::ChanW-1:0]    in_color_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [djob_pkg::ChanW-1:0]    out_red,
  output logic [djob_pkg::ChanW-1:0]    out_green,
  output logic [djob_pkg::ChanW-1:0]    out_blue,
  output logic                          out_overlaid,
  input  logic                          cfg_we,
  input  logic [djob_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [djob_pkg::CfgW-1:0]     cfg_data
);
  import djob_pkg::*;

  localparam int NStg = 9;

  logic [ScaleW-1:0] scale_r;
  logic [MmW-1:0]    min_r;
  logic [MmW-1:0]    max_r;
  logic [AlphaW-1:0] alpha_r;
  logic              enable_r;

  logic [NStg:1] v_r;
  logic [NStg:1] v_nxt;
  logic [NStg:1] en;

  div_t  dq [0:4];
  side_t ds [0:4];

  // a stage loads when empty or when the next stage moves
  always_comb begin
    en[NStg] = !v_r[NStg] || out_ready;
    for (int k = NStg - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[1]) v_nxt[1] = in_valid;
    for (int k = 2; k <= NStg; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      scale_r  <= SCALE_RST;
      min_r    <= MIN_RST;
      max_r    <= MAX_RST;
      alpha_r  <= ALPHA_RST;
      enable_r <= 1'b1;
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALE:  scale_r  <= cfg_data[ScaleW-1:0];
          CFG_MIN:    min_r    <= cfg_data[MmW-1:0];
          CFG_MAX:    max_r    <= cfg_data[MmW-1:0];
          CFG_ALPHA:  alpha_r  <= cfg_data[AlphaW-1:0];
          CFG_ENABLE: enable_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  djob_front u_front (
    .clk            (clk),
    .en             (en[3:1]),
    .raw_depth      (in_raw_depth),
    .color_red      (in_color_red),
    .color_green    (in_color_green),
    .color_blue     (in_color_blue),
    .scale          (scale_r),
    .min_mm         (min_r),
    .max_mm         (max_r),
    .overlay_enable (enable_r),
    .div_o          (dq[0]),
    .side_o         (ds[0])
  );

  for (genvar g = 0; g < 4; g++) begin : g_div
    djob_div #(
      .HiBit (QuoW - 1 - 2 * g)
    ) u_div (
      .clk    (clk),
      .en     (en[4+g]),
      .div_i  (dq[g]),
      .side_i (ds[g]),
      .div_o  (dq[g+1]),
      .side_o (ds[g+1])
    );
  end

  djob_blend u_blend (
    .clk          (clk),
    .en           (en[9:8]),
    .div_i        (dq[4]),
    .side_i       (ds[4]),
    .alpha        (alpha_r),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_overlaid (out_overlaid)
  );

  assign in_ready  = en[1];
  assign out_valid = v_r[NStg];

  // input back-pressure only when every stage holds a pixel
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input blocked with an empty stage");

  // a stalled first divider stage keeps its pixel
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && !en[4]) |=> v_r[4])
    else $error("stalled stage dropped its pixel");

  // a bubble moving into the output stage leaves it empty
  a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (en[9] && !v_r[8]) |=> !v_r[9])
    else $error("output valid without a pixel behind it");

endmodule
